>>> rtl/core/spde_pkg.sv
// Shared constants and fixed-point helpers for the delay-embedding PCA block.
// Q16.16 saturation and floor helpers, register indexes, default sizes.
// No dependencies.
package spde_pkg;

	localparam int DIM_DEF        = 8;
	localparam int MAX_WINDOW_DEF = 64;

	localparam int SAMPLE_W = 16;
	localparam int Q_W      = 32;
	localparam int DELAY_W  = 4;
	localparam int WLEN_W   = 7;
	localparam int CFG_IW   = 8;
	localparam int CFG_DW   = 8;
	localparam int DSR_W    = 40;

	localparam logic [CFG_IW-1:0] REG_EMBED_DELAY   = 8'd0;
	localparam logic [CFG_IW-1:0] REG_WINDOW_LENGTH = 8'd1;

	localparam logic [DELAY_W-1:0] EMBED_DELAY_RST   = 4'd1;
	localparam logic [WLEN_W-1:0]  WINDOW_LENGTH_RST = 7'd64;
	localparam int                 WINDOW_MIN        = 16;

	localparam logic signed [Q_W-1:0] ONE_Q   = 32'sh0001_0000;
	localparam logic signed [63:0]    S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0]    S32_MIN = -64'sd2147483648;

	function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] x);
		if (x > S32_MAX)
			return 32'sh7FFF_FFFF;
		else if (x < S32_MIN)
			return 32'sh8000_0000;
		else
			return x[31:0];
	endfunction

	function automatic logic signed [Q_W-1:0] satfl(input logic signed [63:0] x);
		return sat32(x >>> 16);
	endfunction

	function automatic logic signed [63:0] sx64(input logic signed [Q_W-1:0] x);
		return {{32{x[31]}}, x};
	endfunction

	function automatic logic signed [32:0] sx33(input logic signed [Q_W-1:0] x);
		return {x[31], x};
	endfunction

	function automatic logic signed [32:0] abs33(input logic signed [Q_W-1:0] x);
		logic signed [32:0] e;
		e = {x[31], x};
		return x[31] ? -e : e;
	endfunction

endpackage

>>> rtl/core/spde_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the sample window, covariance and scatter stores. No dependencies.
module spde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/streaming_pca_delay_embedding.sv
// Top level of the streaming two-component PCA over a delay embedding.
// Depends on spde_pkg and spde_ram.
// Sequencer, shared multiplier, radix-2 divider and square-root unit.

// One sample in, one result out. After reset a clearing pass over
// max(MAX_WINDOW, DIM*DIM) addresses zeroes the window and matrix stores, and
// no sample is taken meanwhile. Each sample then runs up to DIM*DIM + 3*DIM
// divisions, two square roots and the window reads, multiply-accumulates and
// sequencing; the 64-step divider takes most of that time. Until the window
// holds more than (DIM-1)*tau samples (tau the embed delay, 0 read as 1), a
// sample returns valid_res = 0 with zero projections. s_axis_tready is high
// only between samples. A finished result moves to the output register and
// waits there until taken; the next sample is accepted meanwhile, and its
// result holds until the output register frees.
module streaming_pca_delay_embedding
	import spde_pkg::*;
#(
	parameter int DIM        = DIM_DEF,
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [15:0]         s_axis_tdata,  // [15:0] sample
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [63:0]         m_axis_tdata,  // [31:0] proj_x, [63:32] proj_y
	output logic                m_axis_tuser,  // [0] valid_res
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_DW-1:0]   cfg_data
);

	localparam int IW     = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int NCOV   = DIM * DIM;
	localparam int KAW    = $clog2(NCOV);
	localparam int WIN_AW = $clog2(MAX_WINDOW);
	localparam int CW     = $clog2(MAX_WINDOW + 1);
	localparam int XW     = $clog2(MAX_WINDOW + 256) + 1;
	localparam int CLR_N  = (MAX_WINDOW > NCOV) ? MAX_WINDOW : NCOV;
	localparam int CLRW   = $clog2(CLR_N + 1);

	typedef enum logic [5:0] {
		ST_CLEAR, ST_IDLE,
		ST_OLD_RD, ST_OLD_WT, ST_OLD_GET, ST_WRITE,
		ST_NEW_RD, ST_NEW_WT, ST_NEW_GET,
		ST_MEAN_DIV, ST_MEAN_UPD,
		ST_COV_RD, ST_COV_WT, ST_COV_GET, ST_COV_FUP, ST_COV_GUP,
		ST_Z_RD, ST_Z_WT, ST_Z_M1, ST_Z_M2, ST_Z_A2,
		ST_DOT_M, ST_DOT_A, ST_SQ_START, ST_SQRT, ST_NRM_R,
		ST_NZ_DIV, ST_NZ_UPD, ST_PR_END, ST_GS_M, ST_GS_A,
		ST_SL_END, ST_NEG, ST_P_END, ST_DIV, ST_OUT
	} state_t;

	typedef enum logic [1:0] {DOT_NRM, DOT_PR, DOT_SL, DOT_PRJ} dot_t;

	state_t state_q, ret_q;
	dot_t   dot_q;
	logic   sel_q;

	logic [DELAY_W-1:0] embed_delay_q;
	logic [WLEN_W-1:0]  window_length_q;

	logic [CW-1:0]     count_q;
	logic [WIN_AW-1:0] wp_q;
	logic [CLRW-1:0]   clr_q;
	logic [IW-1:0]     i_q, j_q;
	logic [KAW-1:0]    k_q;
	logic [XW-1:0]     age_q, tau_q, w_q, span_q, n_q, dd_q;
	logic              full_q, tapok_q;
	logic [15:0]       v_q;

	logic signed [Q_W-1:0] mean_q [DIM];
	logic signed [Q_W-1:0] f1_q [DIM];
	logic signed [Q_W-1:0] f2_q [DIM];
	logic signed [Q_W-1:0] o1_q [DIM];
	logic signed [Q_W-1:0] o2_q [DIM];
	logic signed [Q_W-1:0] z1_q [DIM];
	logic signed [Q_W-1:0] z2_q [DIM];
	logic signed [Q_W-1:0] newc_q [DIM];
	logic signed [Q_W-1:0] ac_q [DIM];
	logic signed [Q_W-1:0] oldraw_q [DIM];
	logic signed [Q_W-1:0] newraw_q [DIM];

	logic signed [63:0]    prod_q, acc_q, acc2_q, t1_q;
	logic signed [Q_W-1:0] hold_q, pr_q, res_x_q, res_y_q;
	logic                  vr_q, m_valid_q;
	logic signed [Q_W-1:0] out_x_q, out_y_q;
	logic                  out_v_q;

	logic [63:0]       div_dvd_q;
	logic [DSR_W-1:0]  div_rem_q, div_dsr_q, nrm_q;
	logic              div_neg_q;
	logic [5:0]        div_cnt_q;
	logic [63:0]       sq_v_q, sq_r_q;
	logic [4:0]        sq_cnt_q;

	logic              win_we_q, cov_we_q, scat_we_q;
	logic [WIN_AW-1:0] win_waddr_q, win_raddr_q;
	logic [15:0]       win_wdata_q, win_rdata;
	logic [KAW-1:0]    cov_waddr_q, cov_raddr_q;
	logic [Q_W-1:0]    cov_wdata_q, scat_wdata_q, cov_rdata, scat_rdata;

	spde_ram #(.WIDTH(16), .DEPTH(MAX_WINDOW)) u_win (
		.clk(clk), .we(win_we_q), .waddr(win_waddr_q), .wdata(win_wdata_q),
		.raddr(win_raddr_q), .rdata(win_rdata)
	);
	spde_ram #(.WIDTH(Q_W), .DEPTH(NCOV)) u_cov (
		.clk(clk), .we(cov_we_q), .waddr(cov_waddr_q), .wdata(cov_wdata_q),
		.raddr(cov_raddr_q), .rdata(cov_rdata)
	);
	spde_ram #(.WIDTH(Q_W), .DEPTH(NCOV)) u_scat (
		.clk(clk), .we(scat_we_q), .waddr(cov_waddr_q), .wdata(scat_wdata_q),
		.raddr(cov_raddr_q), .rdata(scat_rdata)
	);

	logic [XW-1:0]     tau_c, w_c, span_c, cnt_new, rd_t;
	logic [WIN_AW-1:0] rd_addr, wp_nx;
	logic signed [Q_W-1:0] cov_rd, scat_rd, zsel, comp_sel, old_sel, tapval;
	logic signed [Q_W-1:0] mean_new, scat_new;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [63:0] dot_term, dstart_x, div_q;
	logic [DSR_W-1:0]   dstart_d;
	logic [DSR_W:0]     rem_sh, rem_sub;
	logic               rem_ge;
	logic [63:0]        sq_bit, sq_t;
	logic               last_i, last_j, last_k;

	assign cov_rd   = $signed(cov_rdata);
	assign scat_rd  = $signed(scat_rdata);
	assign zsel     = sel_q ? z2_q[i_q] : z1_q[i_q];
	assign comp_sel = sel_q ? f2_q[i_q] : f1_q[i_q];
	assign old_sel  = sel_q ? o2_q[i_q] : o1_q[i_q];
	assign tapval   = $signed({{8{win_rdata[15]}}, win_rdata, 8'h00});
	assign last_i   = (i_q == IW'(DIM - 1));
	assign last_j   = (j_q == IW'(DIM - 1));
	assign last_k   = (k_q == KAW'(NCOV - 1));
	assign wp_nx    = (wp_q == WIN_AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;

	always_comb begin
		tau_c  = (embed_delay_q == '0) ? XW'(1) : XW'(embed_delay_q);
		w_c    = XW'(window_length_q);
		if (w_c < XW'(WINDOW_MIN))
			w_c = XW'(WINDOW_MIN);
		if (w_c > XW'(MAX_WINDOW))
			w_c = XW'(MAX_WINDOW);
		span_c  = XW'((DIM - 1) * tau_c);
		cnt_new = full_q ? w_q : XW'(count_q) + 1'b1;
		rd_t    = XW'(wp_q) + XW'(MAX_WINDOW) - age_q;
		rd_addr = (rd_t >= XW'(MAX_WINDOW)) ? WIN_AW'(rd_t - XW'(MAX_WINDOW))
		                                    : WIN_AW'(rd_t);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_COV_RD: begin
				mul_a = full_q ? sx33(newc_q[i_q]) : sx33(ac_q[i_q]);
				mul_b = sx33(newc_q[j_q]);
			end
			ST_COV_WT: begin
				mul_a = sx33(ac_q[i_q]);
				mul_b = sx33(ac_q[j_q]);
			end
			ST_Z_M1: begin
				mul_a = sx33(cov_rd);
				mul_b = sx33(f1_q[j_q]);
			end
			ST_Z_M2: begin
				mul_a = sx33(cov_rd);
				mul_b = sx33(f2_q[j_q]);
			end
			ST_GS_M: begin
				mul_a = sx33(pr_q);
				mul_b = sx33(f1_q[i_q]);
			end
			ST_DOT_M: begin
				case (dot_q)
					DOT_NRM: begin
						mul_a = abs33(zsel);
						mul_b = abs33(zsel);
					end
					DOT_PR: begin
						mul_a = sx33(f1_q[i_q]);
						mul_b = sx33(z2_q[i_q]);
					end
					DOT_SL: begin
						mul_a = sx33(comp_sel);
						mul_b = sx33(old_sel);
					end
					default: begin
						mul_a = sx33(newc_q[i_q]);
						mul_b = sx33(comp_sel);
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign dot_term = (dot_q == DOT_NRM) ? $signed({4'b0, prod_q[63:4]}) : prod_q;

	always_comb begin
		mean_new = sat32(sx64(mean_q[i_q]) + div_q);
		scat_new = sat32(sx64(scat_rd) + t1_q);
		dstart_x = '0;
		dstart_d = DSR_W'(n_q);
		case (state_q)
			ST_MEAN_DIV:
				dstart_x = sx64(newraw_q[i_q]) -
				           sx64(full_q ? oldraw_q[i_q] : mean_q[i_q]);
			ST_COV_GET: begin
				if (full_q) begin
					dstart_x = t1_q - (prod_q >>> 16);
				end else begin
					dstart_x = sx64(scat_new);
					dstart_d = DSR_W'(dd_q);
				end
			end
			ST_NZ_DIV: begin
				dstart_x = sx64(zsel) <<< 16;
				dstart_d = nrm_q;
			end
			default: dstart_x = '0;
		endcase
	end

	assign div_q   = div_neg_q ? -$signed(div_dvd_q) : $signed(div_dvd_q);
	assign rem_sh  = {div_rem_q, div_dvd_q[63]};
	assign rem_ge  = (rem_sh >= {1'b0, div_dsr_q});
	assign rem_sub = rem_sh - {1'b0, div_dsr_q};
	assign sq_bit  = 64'h4000_0000_0000_0000 >> {sq_cnt_q, 1'b0};
	assign sq_t    = sq_r_q + sq_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			ret_q           <= ST_IDLE;
			dot_q           <= DOT_NRM;
			sel_q           <= 1'b0;
			embed_delay_q   <= EMBED_DELAY_RST;
			window_length_q <= WINDOW_LENGTH_RST;
			count_q         <= '0;
			wp_q            <= '0;
			clr_q           <= '0;
			i_q             <= '0;
			j_q             <= '0;
			k_q             <= '0;
			div_cnt_q       <= '0;
			sq_cnt_q        <= '0;
			m_valid_q       <= 1'b0;
			out_x_q         <= '0;
			out_y_q         <= '0;
			out_v_q         <= 1'b0;
			win_we_q        <= 1'b0;
			cov_we_q        <= 1'b0;
			scat_we_q       <= 1'b0;
			for (int m = 0; m < DIM; m++) begin
				mean_q[m] <= '0;
				f1_q[m]   <= (m == 0) ? ONE_Q : '0;
				f2_q[m]   <= (m == 1) ? ONE_Q : '0;
			end
		end else begin
			win_we_q  <= 1'b0;
			cov_we_q  <= 1'b0;
			scat_we_q <= 1'b0;
			if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_EMBED_DELAY:   embed_delay_q   <= cfg_data[DELAY_W-1:0];
					REG_WINDOW_LENGTH: window_length_q <= cfg_data[WLEN_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_CLEAR: begin
					win_we_q     <= (clr_q < CLRW'(MAX_WINDOW));
					cov_we_q     <= (clr_q < CLRW'(NCOV));
					scat_we_q    <= (clr_q < CLRW'(NCOV));
					win_waddr_q  <= clr_q[WIN_AW-1:0];
					cov_waddr_q  <= clr_q[KAW-1:0];
					win_wdata_q  <= '0;
					cov_wdata_q  <= '0;
					scat_wdata_q <= '0;
					clr_q        <= clr_q + 1'b1;
					if (clr_q == CLRW'(CLR_N - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						v_q    <= s_axis_tdata;
						tau_q  <= tau_c;
						w_q    <= w_c;
						span_q <= span_c;
						full_q <= (XW'(count_q) >= w_c);
						o1_q   <= f1_q;
						o2_q   <= f2_q;
						i_q    <= '0;
						age_q  <= w_c - 1'b1 - span_c;
						state_q <= (span_c < w_c) ? ST_OLD_RD : ST_WRITE;
					end
				end
				ST_OLD_RD: begin
					win_raddr_q <= rd_addr;
					state_q     <= ST_OLD_WT;
				end
				ST_OLD_WT: state_q <= ST_OLD_GET;
				ST_OLD_GET: begin
					oldraw_q[i_q] <= tapval;
					if (last_i) begin
						state_q <= ST_WRITE;
					end else begin
						i_q     <= i_q + 1'b1;
						age_q   <= age_q + tau_q;
						state_q <= ST_OLD_RD;
					end
				end
				ST_WRITE: begin
					wp_q        <= wp_nx;
					win_we_q    <= 1'b1;
					win_waddr_q <= wp_nx;
					win_wdata_q <= v_q;
					count_q     <= CW'(cnt_new);
					n_q         <= cnt_new - span_q;
					dd_q        <= (cnt_new - span_q > XW'(1)) ? cnt_new - span_q - 1'b1
					                                          : XW'(1);
					i_q         <= '0;
					age_q       <= '0;
					if (cnt_new <= span_q) begin
						vr_q    <= 1'b0;
						res_x_q <= '0;
						res_y_q <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_NEW_RD;
					end
				end
				ST_NEW_RD: begin
					win_raddr_q <= rd_addr;
					tapok_q     <= (age_q < XW'(MAX_WINDOW));
					state_q     <= ST_NEW_WT;
				end
				ST_NEW_WT: state_q <= ST_NEW_GET;
				ST_NEW_GET: begin
					newraw_q[i_q] <= tapok_q ? tapval : '0;
					if (last_i) begin
						i_q     <= '0;
						state_q <= ST_MEAN_DIV;
					end else begin
						i_q     <= i_q + 1'b1;
						age_q   <= age_q + tau_q;
						state_q <= ST_NEW_RD;
					end
				end
				ST_MEAN_DIV: begin
					ac_q[i_q] <= sat32(sx64(full_q ? oldraw_q[i_q] : newraw_q[i_q]) -
					                   sx64(mean_q[i_q]));
					div_dvd_q <= dstart_x[63] ? 64'(-dstart_x) : 64'(dstart_x);
					div_neg_q <= dstart_x[63];
					div_dsr_q <= dstart_d;
					div_rem_q <= '0;
					div_cnt_q <= '0;
					ret_q     <= ST_MEAN_UPD;
					state_q   <= ST_DIV;
				end
				ST_MEAN_UPD: begin
					mean_q[i_q] <= mean_new;
					newc_q[i_q] <= sat32(sx64(newraw_q[i_q]) - sx64(mean_new));
					if (last_i) begin
						i_q    <= '0;
						j_q    <= '0;
						k_q    <= '0;
						acc_q  <= '0;
						acc2_q <= '0;
						state_q <= (full_q && n_q <= XW'(1)) ? ST_Z_RD : ST_COV_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_MEAN_DIV;
					end
				end
				ST_COV_RD: begin
					cov_raddr_q <= k_q;
					prod_q      <= mul_p[63:0];
					state_q     <= ST_COV_WT;
				end
				ST_COV_WT: begin
					t1_q    <= prod_q >>> 16;
					prod_q  <= mul_p[63:0];
					state_q <= ST_COV_GET;
				end
				ST_COV_GET: begin
					hold_q      <= cov_rd;
					cov_waddr_q <= k_q;
					if (!full_q) begin
						scat_we_q    <= 1'b1;
						scat_wdata_q <= scat_new;
					end
					div_dvd_q <= dstart_x[63] ? 64'(-dstart_x) : 64'(dstart_x);
					div_neg_q <= dstart_x[63];
					div_dsr_q <= dstart_d;
					div_rem_q <= '0;
					div_cnt_q <= '0;
					ret_q     <= full_q ? ST_COV_FUP : ST_COV_GUP;
					state_q   <= ST_DIV;
				end
				ST_COV_FUP, ST_COV_GUP: begin
					cov_we_q    <= 1'b1;
					cov_wdata_q <= (state_q == ST_COV_FUP) ?
					               sat32(sx64(hold_q) + div_q) : div_q[31:0];
					k_q <= k_q + 1'b1;
					j_q <= last_j ? '0 : j_q + 1'b1;
					if (last_j)
						i_q <= i_q + 1'b1;
					if (last_k) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						acc_q   <= '0;
						acc2_q  <= '0;
						state_q <= ST_Z_RD;
					end else begin
						state_q <= ST_COV_RD;
					end
				end
				ST_Z_RD: begin
					cov_raddr_q <= k_q;
					state_q     <= ST_Z_WT;
				end
				ST_Z_WT: state_q <= ST_Z_M1;
				ST_Z_M1: begin
					prod_q  <= mul_p[63:0];
					state_q <= ST_Z_M2;
				end
				ST_Z_M2: begin
					acc_q   <= acc_q + prod_q;
					prod_q  <= mul_p[63:0];
					state_q <= ST_Z_A2;
				end
				ST_Z_A2: begin
					if (last_j) begin
						z1_q[i_q] <= satfl(acc_q);
						z2_q[i_q] <= satfl(acc2_q + prod_q);
						acc_q     <= '0;
						acc2_q    <= '0;
						i_q       <= i_q + 1'b1;
						j_q       <= '0;
					end else begin
						acc2_q <= acc2_q + prod_q;
						j_q    <= j_q + 1'b1;
					end
					k_q <= k_q + 1'b1;
					if (last_k) begin
						sel_q   <= 1'b0;
						i_q     <= '0;
						dot_q   <= DOT_NRM;
						ret_q   <= ST_SQ_START;
						state_q <= ST_DOT_M;
					end else begin
						state_q <= ST_Z_RD;
					end
				end
				ST_DOT_M: begin
					prod_q  <= mul_p[63:0];
					state_q <= ST_DOT_A;
				end
				ST_DOT_A: begin
					acc_q <= acc_q + dot_term;
					if (last_i) begin
						i_q     <= '0;
						state_q <= ret_q;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_DOT_M;
					end
				end
				ST_SQ_START: begin
					sq_v_q   <= 64'(acc_q);
					sq_r_q   <= '0;
					sq_cnt_q <= '0;
					state_q  <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_v_q >= sq_t) begin
						sq_v_q <= sq_v_q - sq_t;
						sq_r_q <= (sq_r_q >> 1) + sq_bit;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == 5'd31)
						state_q <= ST_NRM_R;
				end
				ST_NRM_R: begin
					nrm_q <= DSR_W'(sq_r_q) << 2;
					i_q   <= '0;
					acc_q <= '0;
					if (sq_r_q != '0) begin
						state_q <= ST_NZ_DIV;
					end else if (!sel_q) begin
						dot_q   <= DOT_PR;
						ret_q   <= ST_PR_END;
						state_q <= ST_DOT_M;
					end else begin
						sel_q   <= 1'b0;
						dot_q   <= DOT_SL;
						ret_q   <= ST_SL_END;
						state_q <= ST_DOT_M;
					end
				end
				ST_NZ_DIV: begin
					div_dvd_q <= dstart_x[63] ? 64'(-dstart_x) : 64'(dstart_x);
					div_neg_q <= dstart_x[63];
					div_dsr_q <= dstart_d;
					div_rem_q <= '0;
					div_cnt_q <= '0;
					ret_q     <= ST_NZ_UPD;
					state_q   <= ST_DIV;
				end
				ST_NZ_UPD: begin
					if (sel_q)
						f2_q[i_q] <= sat32(div_q);
					else
						f1_q[i_q] <= sat32(div_q);
					if (last_i) begin
						i_q   <= '0;
						acc_q <= '0;
						if (!sel_q) begin
							dot_q   <= DOT_PR;
							ret_q   <= ST_PR_END;
							state_q <= ST_DOT_M;
						end else begin
							sel_q   <= 1'b0;
							dot_q   <= DOT_SL;
							ret_q   <= ST_SL_END;
							state_q <= ST_DOT_M;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_NZ_DIV;
					end
				end
				ST_PR_END: begin
					pr_q    <= satfl(acc_q);
					i_q     <= '0;
					state_q <= ST_GS_M;
				end
				ST_GS_M: begin
					prod_q  <= mul_p[63:0];
					state_q <= ST_GS_A;
				end
				ST_GS_A: begin
					z2_q[i_q] <= sat32(sx64(z2_q[i_q]) - sx64(satfl(prod_q)));
					if (last_i) begin
						i_q     <= '0;
						sel_q   <= 1'b1;
						acc_q   <= '0;
						dot_q   <= DOT_NRM;
						ret_q   <= ST_SQ_START;
						state_q <= ST_DOT_M;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_GS_M;
					end
				end
				ST_SL_END, ST_NEG: begin
					if (state_q == ST_NEG) begin
						if (sel_q)
							f2_q[i_q] <= sat32(-sx64(f2_q[i_q]));
						else
							f1_q[i_q] <= sat32(-sx64(f1_q[i_q]));
					end
					if (state_q == ST_SL_END && acc_q[63]) begin
						i_q     <= '0;
						state_q <= ST_NEG;
					end else if (state_q == ST_NEG && !last_i) begin
						i_q <= i_q + 1'b1;
					end else begin
						i_q   <= '0;
						acc_q <= '0;
						if (!sel_q) begin
							sel_q <= 1'b1;
							dot_q <= DOT_SL;
							ret_q <= ST_SL_END;
						end else begin
							sel_q <= 1'b0;
							dot_q <= DOT_PRJ;
							ret_q <= ST_P_END;
						end
						state_q <= ST_DOT_M;
					end
				end
				ST_P_END: begin
					acc_q <= '0;
					i_q   <= '0;
					if (!sel_q) begin
						res_x_q <= satfl(acc_q);
						sel_q   <= 1'b1;
						state_q <= ST_DOT_M;
					end else begin
						res_y_q <= satfl(acc_q);
						sel_q   <= 1'b0;
						vr_q    <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					div_rem_q <= rem_ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
					div_dvd_q <= {div_dvd_q[62:0], rem_ge};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 6'd63)
						state_q <= ret_q;
				end
				ST_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						out_x_q   <= res_x_q;
						out_y_q   <= res_y_q;
						out_v_q   <= vr_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {out_y_q, out_x_q};
	assign m_axis_tuser  = out_v_q;

endmodule

>>> tb/spde_checker.sv
`timescale 1ns / 1ps
// Projection checker for streaming_pca_delay_embedding: tracks register writes
// and accepted samples, predicts proj_x/proj_y in Q16.16 and compares results.
// Depends on spde_pkg for register indexes and field widths.
module spde_checker
	import spde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [63:0]       m_axis_tdata,
	input  logic              m_axis_tuser,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	output int                pending,
	output int                errors,
	output int                valid_seen
);

	localparam int N = DIM_DEF;
	localparam int MW = MAX_WINDOW_DEF;

	typedef struct packed {
		logic              valid_res;
		logic signed [31:0] proj_x;
		logic signed [31:0] proj_y;
	} proj_t;

	proj_t projections_due[$];

	int window[MW];
	int unsigned fill_count;
	int mean[N];
	int cov[N*N];
	int scatter[N*N];
	int pc1[N];
	int pc2[N];
	logic [DELAY_W-1:0] tau_reg;
	logic [WLEN_W-1:0]  wlen_reg;

	function automatic int clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return int'(v);
	endfunction

	function automatic longint fl16(longint v);
		return v >>> 16;
	endfunction

	function automatic int dot_q(int a[N], int b[N]);
		longint s;
		s = 0;
		for (int i = 0; i < N; i++)
			s += longint'(a[i]) * longint'(b[i]);
		return clip32(fl16(s));
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint norm_q(int z[N]);
		longint unsigned s;
		longint unsigned a;
		s = 0;
		for (int i = 0; i < N; i++) begin
			a = z[i] < 0 ? longint'(-longint'(z[i])) : longint'(z[i]);
			s += (a * a) >> 4;
		end
		return longint'(root64(s)) * 4;
	endfunction

	function automatic void lock_sign(ref int q[N], input int prev[N]);
		longint s;
		s = 0;
		for (int i = 0; i < N; i++)
			s += longint'(q[i]) * longint'(prev[i]);
		if (s < 0)
			for (int i = 0; i < N; i++)
				q[i] = clip32(-longint'(q[i]));
	endfunction

	function automatic void subspace_step();
		int o1[N], o2[N], z1[N], z2[N];
		longint a, b, nrm;
		int pr;
		o1 = pc1;
		o2 = pc2;
		for (int i = 0; i < N; i++) begin
			a = 0;
			b = 0;
			for (int j = 0; j < N; j++) begin
				a += longint'(cov[i*N+j]) * longint'(pc1[j]);
				b += longint'(cov[i*N+j]) * longint'(pc2[j]);
			end
			z1[i] = clip32(fl16(a));
			z2[i] = clip32(fl16(b));
		end
		nrm = norm_q(z1);
		if (nrm > 0)
			for (int i = 0; i < N; i++)
				pc1[i] = clip32(longint'(z1[i]) * 65536 / nrm);
		pr = dot_q(pc1, z2);
		for (int i = 0; i < N; i++)
			z2[i] = clip32(longint'(z2[i]) - longint'(clip32(fl16(longint'(pr) *
				longint'(pc1[i])))));
		nrm = norm_q(z2);
		if (nrm > 0)
			for (int i = 0; i < N; i++)
				pc2[i] = clip32(longint'(z2[i]) * 65536 / nrm);
		lock_sign(pc1, o1);
		lock_sign(pc2, o2);
	endfunction

	function automatic int at_age(int unsigned age);
		return age < MW ? window[age] : 0;
	endfunction

	function automatic proj_t embed_and_project(logic signed [15:0] smp);
		proj_t r;
		int unsigned tau, w, span, n;
		bit full;
		int oldraw[N], oldc[N], newraw[N], newc[N], dold[N];
		longint c, d;
		tau = tau_reg == 0 ? 1 : tau_reg;
		w = wlen_reg < WINDOW_MIN ? WINDOW_MIN : wlen_reg;
		if (w > MW)
			w = MW;
		span = (N - 1) * tau;
		full = fill_count >= w;
		if (span < w)
			for (int i = 0; i < N; i++)
				oldraw[i] = at_age(w - 1 - span + i * tau) * 256;
		for (int i = MW - 1; i > 0; i--)
			window[i] = window[i-1];
		window[0] = smp;
		fill_count = full ? w : fill_count + 1;
		r = '0;
		if (fill_count < span + 1)
			return r;
		n = full ? w - span : fill_count - span;
		for (int i = 0; i < N; i++) begin
			newraw[i] = at_age(i * tau) * 256;
			if (full) begin
				oldc[i] = clip32(longint'(oldraw[i]) - mean[i]);
				mean[i] = clip32(longint'(mean[i]) +
					(longint'(newraw[i]) - oldraw[i]) / longint'(n));
			end else begin
				dold[i] = clip32(longint'(newraw[i]) - mean[i]);
				mean[i] = clip32(longint'(mean[i]) +
					(longint'(newraw[i]) - mean[i]) / longint'(n));
			end
		end
		for (int i = 0; i < N; i++)
			newc[i] = clip32(longint'(newraw[i]) - mean[i]);
		if (full) begin
			if (n > 1)
				for (int i = 0; i < N; i++)
					for (int j = 0; j < N; j++) begin
						c = fl16(longint'(newc[i]) * newc[j]) -
							fl16(longint'(oldc[i]) * oldc[j]);
						cov[i*N+j] = clip32(longint'(cov[i*N+j]) + c / longint'(n));
					end
		end else begin
			d = n > 1 ? longint'(n) - 1 : 1;
			for (int i = 0; i < N; i++)
				for (int j = 0; j < N; j++) begin
					scatter[i*N+j] = clip32(longint'(scatter[i*N+j]) +
						fl16(longint'(dold[i]) * newc[j]));
					cov[i*N+j] = int'(longint'(scatter[i*N+j]) / d);
				end
		end
		subspace_step();
		r.valid_res = 1'b1;
		r.proj_x = dot_q(newc, pc1);
		r.proj_y = dot_q(newc, pc2);
		return r;
	endfunction

	initial begin
		foreach (window[i]) window[i] = 0;
		foreach (mean[i]) mean[i] = 0;
		foreach (cov[i]) cov[i] = 0;
		foreach (scatter[i]) scatter[i] = 0;
		foreach (pc1[i]) pc1[i] = 0;
		foreach (pc2[i]) pc2[i] = 0;
		pc1[0] = 65536;
		pc2[1] = 65536;
		fill_count = 0;
		tau_reg = EMBED_DELAY_RST;
		wlen_reg = WINDOW_LENGTH_RST;
		pending = 0;
		errors = 0;
		valid_seen = 0;
	end

	always @(posedge clk) begin
		proj_t got, want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_EMBED_DELAY)
					tau_reg = cfg_data[DELAY_W-1:0];
				else if (cfg_index == REG_WINDOW_LENGTH)
					wlen_reg = cfg_data[WLEN_W-1:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				projections_due.push_back(embed_and_project(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got.valid_res = m_axis_tuser;
				got.proj_x = m_axis_tdata[31:0];
				got.proj_y = m_axis_tdata[63:32];
				if (projections_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result tuser=%0b x=%0d y=%0d",
							got.valid_res, got.proj_x, got.proj_y);
				end else begin
					want = projections_due.pop_front();
					if (want.valid_res)
						valid_seen++;
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp v=%0b x=%0d y=%0d, got v=%0b x=%0d y=%0d",
								want.valid_res, want.proj_x, want.proj_y,
								got.valid_res, got.proj_x, got.proj_y);
					end
				end
			end
			pending = projections_due.size();
		end
	end

endmodule

>>> tb/streaming_pca_delay_embedding_test.sv
`timescale 1ns / 1ps
// Top of the streaming_pca_delay_embedding testbench: clock, reset, sample
// stimulus, register writes, back-pressure and verdict.
// Depends on spde_pkg, the block and spde_checker.
module streaming_pca_delay_embedding_test;
	import spde_pkg::*;

	localparam int MODE_FREE  = 0;
	localparam int MODE_SRC   = 1;
	localparam int MODE_SINK  = 2;
	localparam int MODE_BOTH  = 3;
	localparam int STALL_LIMIT = 400000;
	localparam int HOLD_CYCLES = 30000;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid, cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	int pending, errors, valid_seen;
	int mode;
	bit long_hold;
	int samples_sent, idle_cycles;

	streaming_pca_delay_embedding i_dut (.*);

	spde_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	initial begin
		m_axis_tready = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				long_hold = 0;
			end else if (mode == MODE_SINK || mode == MODE_BOTH)
				m_axis_tready <= $urandom_range(99) >= (mode == MODE_SINK ? 49 : 29);
			else
				m_axis_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic push_sample(logic [15:0] smp);
		int gap_pct;
		gap_pct = mode == MODE_SRC ? 49 : mode == MODE_BOTH ? 29 : 0;
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= smp;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		samples_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic random_phase(int m, logic [7:0] dly, logic [7:0] wlen, int count);
		drain();
		mode = m;
		write_reg(REG_EMBED_DELAY, dly);
		write_reg(REG_WINDOW_LENGTH, wlen);
		for (int i = 0; i < count; i++)
			push_sample($urandom_range(3) == 0 ? 16'($urandom) :
				16'($signed($urandom_range(4095)) - 2048));
	endtask

	initial begin
		logic [15:0] edge_vals[6];
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		mode = MODE_FREE;
		long_hold = 0;
		samples_sent = 0;
		idle_cycles = 0;
		edge_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555};
		wait (arst_n);
		@(posedge clk);
		for (int i = 0; i < 20; i++)
			push_sample(edge_vals[i % 6]);
		random_phase(MODE_SRC, 8'h03, 8'd40, 115);
		random_phase(MODE_SINK, 8'hF0, 8'd16, 40);
		long_hold = 1;
		for (int i = 0; i < 75; i++)
			push_sample(16'($urandom));
		random_phase(MODE_BOTH, 8'd9, 8'd64, 115);
		random_phase(MODE_FREE, 8'hFF, 8'hFF, 115);
		random_phase(MODE_SRC, 8'd2, 8'h00, 115);
		drain();
		write_reg(8'd2, 8'h05);
		write_reg(8'hFF, 8'hAA);
		random_phase(MODE_SINK, 8'd1, 8'd100, 115);
		random_phase(MODE_BOTH, 8'd5, 8'd50, 115);
		random_phase(MODE_FREE, 8'd4, 8'd30, 105);
		drain();
		repeat (50) @(posedge clk);
		$display("Sent %0d samples over nine register settings (tap spacing 0..15, window 0..127)",
			samples_sent);
		$display("with idle and stall phases; %0d valid projections checked", valid_seen);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/spde_pkg.sv
rtl/core/spde_ram.sv
rtl/core/streaming_pca_delay_embedding.sv
tb/spde_checker.sv
tb/streaming_pca_delay_embedding_test.sv
